FILE: rtl/arba_pkg.sv
// Shared types and constants of the atlas rectangle bitmap allocator.
package arba_pkg;

    localparam int ROWS_PER_PAGE = 32;
    localparam int WORD_W        = 32;
    localparam int CELL_SHIFT    = 3;
    localparam int MIN_PX        = 8;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_COLS,
        S_ORIGIN,
        S_READ,
        S_WAIT,
        S_EVAL,
        S_MARK,
        S_MWAIT,
        S_FAIL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic acc_clr;
        logic acc_en;
    } t_fit_ctrl;

endpackage

FILE: rtl/atlas_rect_bitmap_allocator.sv
// Top level: request sequencer, occupancy bitmap and failure counter of the allocator.
//
// After reset the block clears its bitmap, one word per cycle, and holds busy high
// meanwhile. A request is taken when start is high and busy is low. It then lists the
// candidate columns and tries each candidate origin row, page by page, reading the covered
// row words one per cycle through the single read port of the bitmap and checking all
// column candidates of that row together. A successful placement then marks the bits by
// read-modify-write. The result is shown for exactly one cycle with o_done; the receiver
// cannot stall it.
module atlas_rect_bitmap_allocator #(
    parameter int PAGE_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [9:0]  i_width_px,
    input  logic [9:0]  i_height_px,
    input  logic        i_clip_to_grid,
    output logic        busy,
    output logic        o_done,
    output logic        o_found,
    output logic [3:0]  o_page_index,
    output logic [4:0]  o_cell_column,
    output logic [4:0]  o_cell_row,
    output logic [7:0]  o_width_minus_one,
    output logic [7:0]  o_height_minus_one,
    output logic [31:0] o_failures_so_far
);

    import arba_pkg::*;

    localparam int               Depth    = PAGE_COUNT * ROWS_PER_PAGE;
    localparam int               AddrW    = $clog2(Depth);
    localparam logic [3:0]       LastPage = 4'(PAGE_COUNT - 1);
    localparam logic [9:0]       RowLimit = 10'(Depth);
    localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

    t_state           r_state, n_state;
    logic [7:0]       r_wc, r_hc;
    logic [5:0]       r_col_lim, r_row_lim;
    t_word            r_base_mask, r_cvec, r_mask;
    logic [7:0]       r_col, r_row;
    logic [3:0]       r_page;
    logic [6:0]       r_k;
    logic             r_blocked;
    logic [4:0]       r_col_sel;
    logic             r_found;
    logic [7:0]       r_wm1, r_hm1;
    logic [31:0]      r_fail_cnt;
    logic             r_rd_pend, r_wr_pend;
    logic [AddrW-1:0] r_wr_addr, r_clr_addr;

    logic [9:0]       w_cl, h_cl;
    logic [7:0]       wc, hc;
    logic [9:0]       idx;
    logic             in_range, last_k, col_more, row_more, hit;
    logic             ram_we, ram_re;
    logic [AddrW-1:0] ram_waddr;
    t_word            ram_wdata, ram_rdata, fit_mask;
    logic [4:0]       fit_col;
    logic             fit_hit;
    t_fit_ctrl        fit_ctrl;

    always_comb begin
        w_cl = (i_width_px < 10'(MIN_PX)) ? 10'(MIN_PX) : i_width_px;
        h_cl = (i_height_px < 10'(MIN_PX)) ? 10'(MIN_PX) : i_height_px;
        wc   = 8'(({1'b0, w_cl} + 11'd7) >> CELL_SHIFT);
        hc   = 8'(({1'b0, h_cl} + 11'd7) >> CELL_SHIFT);
    end

    assign idx      = {1'b0, r_page, r_row[4:0]} + {3'b000, r_k};
    assign in_range = idx < RowLimit;
    assign last_k   = ({1'b0, r_k} + 8'd1) == r_hc;
    assign col_more = r_col < {2'b00, r_col_lim};
    assign row_more = r_row < {2'b00, r_row_lim};
    assign hit      = fit_hit && !r_blocked;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr_addr == LastAddr) n_state = S_IDLE;
            S_IDLE:   if (start) n_state = S_COLS;
            S_COLS: begin
                if (!col_more) begin
                    n_state = (r_cvec == '0) ? S_FAIL : S_ORIGIN;
                end
            end
            S_ORIGIN: begin
                if (row_more) begin
                    n_state = S_READ;
                end else if (r_page == LastPage) begin
                    n_state = S_FAIL;
                end
            end
            S_READ:   if (!in_range || last_k) n_state = S_WAIT;
            S_WAIT:   n_state = S_EVAL;
            S_EVAL:   n_state = hit ? S_MARK : S_ORIGIN;
            S_MARK:   if (last_k) n_state = S_MWAIT;
            S_MWAIT:  n_state = S_DONE;
            S_FAIL:   n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy             = r_state != S_IDLE;
        o_done           = r_state == S_DONE;
        ram_re           = ((r_state == S_READ) && in_range) || (r_state == S_MARK);
        fit_ctrl.acc_clr = r_state == S_ORIGIN;
        fit_ctrl.acc_en  = r_rd_pend;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = r_wr_pend;
            ram_waddr = r_wr_addr;
            ram_wdata = ram_rdata | r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_fail_cnt <= '0;
            r_rd_pend  <= 1'b0;
            r_wr_pend  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == S_READ) && in_range;
            r_wr_pend <= r_state == S_MARK;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_FAIL) begin
                r_fail_cnt <= r_fail_cnt + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_wc        <= wc;
                    r_hc        <= hc;
                    r_wm1       <= i_width_px[7:0] - 8'd1;
                    r_hm1       <= i_height_px[7:0] - 8'd1;
                    r_base_mask <= (wc >= 8'd32) ? '1 : ~('1 << wc[4:0]);
                    if (i_clip_to_grid) begin
                        r_col_lim <= (wc >= 8'd32) ? 6'd0 : 6'd32 - {1'b0, wc[4:0]};
                        r_row_lim <= (hc >= 8'd32) ? 6'd0 : 6'd32 - {1'b0, hc[4:0]};
                    end else begin
                        r_col_lim <= 6'd32;
                        r_row_lim <= 6'd32;
                    end
                    r_col  <= '0;
                    r_cvec <= '0;
                    r_page <= '0;
                    r_row  <= '0;
                end
            end
            S_COLS: begin
                if (col_more) begin
                    r_cvec[r_col[4:0]] <= 1'b1;
                    r_col              <= r_col + r_wc;
                end
            end
            S_ORIGIN: begin
                if (row_more) begin
                    r_k       <= '0;
                    r_blocked <= 1'b0;
                end else if (r_page != LastPage) begin
                    r_page <= r_page + 4'd1;
                    r_row  <= '0;
                end
            end
            S_READ: begin
                if (!in_range) begin
                    r_blocked <= 1'b1;
                end else begin
                    r_k <= r_k + 7'd1;
                end
            end
            S_EVAL: begin
                if (hit) begin
                    r_col_sel <= fit_col;
                    r_mask    <= fit_mask;
                    r_k       <= '0;
                end else begin
                    r_row <= r_row + r_hc;
                end
            end
            S_MARK: begin
                r_k       <= r_k + 7'd1;
                r_wr_addr <= idx[AddrW-1:0];
            end
            S_MWAIT:  r_found <= 1'b1;
            S_FAIL:   r_found <= 1'b0;
            default: begin
            end
        endcase
    end

    arba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (Depth)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (idx[AddrW-1:0]),
        .o_rdata (ram_rdata)
    );

    arba_fit u_fit (
        .i_clk       (i_clk),
        .i_ctrl      (fit_ctrl),
        .i_row_data  (ram_rdata),
        .i_base_mask (r_base_mask),
        .i_cand      (r_cvec),
        .o_hit       (fit_hit),
        .o_col       (fit_col),
        .o_mask      (fit_mask)
    );

    assign o_found            = r_found;
    assign o_page_index       = r_found ? r_page : 4'd0;
    assign o_cell_column      = r_found ? r_col_sel : 5'd0;
    assign o_cell_row         = r_found ? r_row[4:0] : 5'd0;
    assign o_width_minus_one  = r_found ? r_wm1 : 8'd0;
    assign o_height_minus_one = r_found ? r_hm1 : 8'd0;
    assign o_failures_so_far  = r_fail_cnt;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_done)
        else $error("Result strobe lasted more than one cycle.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (row_more && r_cvec[r_col_sel]))
        else $error("Placement reported at an origin that is not a candidate.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_fail_cnt) |-> ((r_state == S_DONE) && !r_found))
        else $error("Failure counter changed outside a failed request.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_READ) || (r_state == S_WAIT) || (r_state == S_EVAL)) |-> !ram_we)
        else $error("Bitmap written during the search.");

endmodule

FILE: rtl/arba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module arba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/arba_fit.sv
// Row accumulator and parallel column fit check with first-fit selection.
module arba_fit (
    input  logic                i_clk,
    input  arba_pkg::t_fit_ctrl i_ctrl,
    input  arba_pkg::t_word     i_row_data,
    input  arba_pkg::t_word     i_base_mask,
    input  arba_pkg::t_word     i_cand,
    output logic                o_hit,
    output logic [4:0]          o_col,
    output arba_pkg::t_word     o_mask
);

    import arba_pkg::*;

    t_word r_acc;
    t_word lane_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc <= r_acc | i_row_data;
        end
    end

    always_comb begin
        for (int c = 0; c < WORD_W; c++) begin
            lane_ok[c] = i_cand[c] && ((r_acc & (i_base_mask << c)) == '0);
        end
    end

    always_comb begin
        o_col = '0;
        for (int c = WORD_W - 1; c >= 0; c--) begin
            if (lane_ok[c]) begin
                o_col = 5'(c);
            end
        end
    end

    assign o_hit  = |lane_ok;
    assign o_mask = i_base_mask << o_col;

endmodule

FILE: verif/atlas_rect_bitmap_allocator_tb.sv
// Self-checking testbench for the atlas rectangle bitmap allocator.
`timescale 1ns / 1ps

module atlas_rect_bitmap_allocator_tb;

    import arba_pkg::*;

    localparam int NUM_PAGES    = 16;
    localparam int MAP_WORDS    = NUM_PAGES * ROWS_PER_PAGE;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 2000;

    typedef struct packed {
        logic        found;
        logic [3:0]  page;
        logic [4:0]  col;
        logic [4:0]  row;
        logic [7:0]  wm1;
        logic [7:0]  hm1;
        logic [31:0] fails;
    } t_alloc_result;

    typedef struct packed {
        logic [9:0]    w;
        logic [9:0]    h;
        logic          clip;
        logic          has_exp;
        t_alloc_result exp;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic [9:0]  i_width_px;
    logic [9:0]  i_height_px;
    logic        i_clip_to_grid;
    logic        busy;
    logic        o_done;
    logic        o_found;
    logic [3:0]  o_page_index;
    logic [4:0]  o_cell_column;
    logic [4:0]  o_cell_row;
    logic [7:0]  o_width_minus_one;
    logic [7:0]  o_height_minus_one;
    logic [31:0] o_failures_so_far;

    logic          req_has_exp;
    t_alloc_result req_exp;

    logic [31:0]   occ_map [MAP_WORDS];
    logic [31:0]   fail_total;
    t_alloc_result pending_allocs [$];
    t_stim_row     dir_rows [$];
    t_alloc_result pred_res;
    t_alloc_result want_res;
    int            err_count;
    int            n_issued;
    int            n_placed;
    int            n_refused;
    int            quiet_run;

    atlas_rect_bitmap_allocator #(
        .PAGE_COUNT(NUM_PAGES)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .i_width_px         (i_width_px),
        .i_height_px        (i_height_px),
        .i_clip_to_grid     (i_clip_to_grid),
        .busy               (busy),
        .o_done             (o_done),
        .o_found            (o_found),
        .o_page_index       (o_page_index),
        .o_cell_column      (o_cell_column),
        .o_cell_row         (o_cell_row),
        .o_width_minus_one  (o_width_minus_one),
        .o_height_minus_one (o_height_minus_one),
        .o_failures_so_far  (o_failures_so_far)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_alloc_result predict_alloc(input logic [9:0] w_px,
                                                    input logic [9:0] h_px,
                                                    input logic clip);
        int            w_eff;
        int            h_eff;
        int            wc;
        int            hc;
        int            col_lim;
        int            row_lim;
        int            base_row;
        logic [31:0]   base_mask;
        logic [31:0]   mask;
        logic          fits;
        t_alloc_result res;
        res = '0;
        w_eff = w_px;
        h_eff = h_px;
        if (w_eff < 8) w_eff = 8;
        if (h_eff < 8) h_eff = 8;
        wc = (w_eff + 7) >> 3;
        hc = (h_eff + 7) >> 3;
        base_mask = (wc >= 32) ? 32'hffff_ffff : ((32'd1 << wc) - 32'd1);
        col_lim = clip ? 32 - wc : 32;
        row_lim = clip ? ROWS_PER_PAGE - hc : ROWS_PER_PAGE;
        for (int pg = 0; pg < NUM_PAGES; pg++) begin
            for (int rw = 0; rw < row_lim; rw += hc) begin
                for (int cl = 0; cl < col_lim; cl += wc) begin
                    mask = base_mask << cl;
                    base_row = pg * ROWS_PER_PAGE + rw;
                    fits = 1'b1;
                    for (int k = 0; k < hc; k++) begin
                        if (base_row + k >= MAP_WORDS) begin
                            fits = 1'b0;
                        end else if ((occ_map[base_row + k] & mask) != 32'd0) begin
                            fits = 1'b0;
                        end
                    end
                    if (fits) begin
                        for (int k = 0; k < hc; k++) begin
                            occ_map[base_row + k] = occ_map[base_row + k] | mask;
                        end
                        res.found = 1'b1;
                        res.page  = pg[3:0];
                        res.col   = cl[4:0];
                        res.row   = rw[4:0];
                        res.wm1   = w_px[7:0] - 8'd1;
                        res.hm1   = h_px[7:0] - 8'd1;
                        res.fails = fail_total;
                        return res;
                    end
                end
            end
        end
        fail_total = fail_total + 32'd1;
        res.fails = fail_total;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_done === 1'b1) begin
                if (pending_allocs.size() == 0) begin
                    $display("%0t: result with no request outstanding", $time);
                    err_count++;
                end else begin
                    want_res = pending_allocs.pop_front();
                    check_field("found", 32'(want_res.found), 32'(o_found));
                    check_field("page_index", 32'(want_res.page), 32'(o_page_index));
                    check_field("cell_column", 32'(want_res.col), 32'(o_cell_column));
                    check_field("cell_row", 32'(want_res.row), 32'(o_cell_row));
                    check_field("width_minus_one", 32'(want_res.wm1),
                                32'(o_width_minus_one));
                    check_field("height_minus_one", 32'(want_res.hm1),
                                32'(o_height_minus_one));
                    check_field("failures_so_far", want_res.fails, o_failures_so_far);
                    if (o_found === 1'b1) n_placed++;
                    else n_refused++;
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                pred_res = predict_alloc(i_width_px, i_height_px, i_clip_to_grid);
                pending_allocs.push_back(req_has_exp ? req_exp : pred_res);
                n_issued++;
            end
        end
    end

    task automatic add_row(input logic [9:0] w, input logic [9:0] h, input logic clip,
                           input logic has_exp, input t_alloc_result exp);
        t_stim_row r;
        r.w = w;
        r.h = h;
        r.clip = clip;
        r.has_exp = has_exp;
        r.exp = exp;
        dir_rows.push_back(r);
    endtask

    task automatic send_request(input logic [9:0] w, input logic [9:0] h,
                                input logic clip, input logic has_exp,
                                input t_alloc_result exp);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet_run > 0) begin
            quiet_run--;
            gap = 0;
        end else if (pick < 3) begin
            quiet_run = $urandom_range(10, 40);
            gap = 0;
        end else if (pick < 40) begin
            gap = 0;
        end else if (pick < 88) begin
            gap = $urandom_range(1, 8);
        end else if (pick < 97) begin
            gap = $urandom_range(9, 120);
        end else begin
            gap = $urandom_range(121, 2500);
        end
        if (gap > 0) begin
            start <= 1'b0;
            i_width_px <= 10'($urandom);
            i_height_px <= 10'($urandom);
            i_clip_to_grid <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_width_px <= w;
        i_height_px <= h;
        i_clip_to_grid <= clip;
        req_has_exp <= has_exp;
        req_exp <= exp;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    initial begin
        int          pick;
        logic [9:0]  w;
        logic [9:0]  h;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_width_px = '0;
        i_height_px = '0;
        i_clip_to_grid = 1'b0;
        req_has_exp = 1'b0;
        req_exp = '0;
        foreach (occ_map[i]) occ_map[i] = '0;
        fail_total = '0;
        err_count = 0;
        n_issued = 0;
        n_placed = 0;
        n_refused = 0;
        quiet_run = 0;

        add_row(10'd0, 10'd0, 1'b0, 1'b1, {1'b1, 4'd0, 5'd0, 5'd0, 8'd255, 8'd255, 32'd0});
        add_row(10'd8, 10'd8, 1'b1, 1'b1, {1'b1, 4'd0, 5'd1, 5'd0, 8'd7, 8'd7, 32'd0});
        add_row(10'd256, 10'd8, 1'b1, 1'b1, {1'b0, 4'd0, 5'd0, 5'd0, 8'd0, 8'd0, 32'd1});
        add_row(10'd8, 10'd1023, 1'b1, 1'b1, {1'b0, 4'd0, 5'd0, 5'd0, 8'd0, 8'd0, 32'd2});
        add_row(10'd1023, 10'd1023, 1'b1, 1'b1, {1'b0, 4'd0, 5'd0, 5'd0, 8'd0, 8'd0, 32'd3});
        add_row(10'd255, 10'd8, 1'b0, 1'b1, {1'b1, 4'd0, 5'd0, 5'd1, 8'd254, 8'd7, 32'd3});
        add_row(10'd1, 10'd7, 1'b0, 1'b0, '0);
        add_row(10'd9, 10'd9, 1'b0, 1'b0, '0);
        add_row(10'd7, 10'd8, 1'b1, 1'b0, '0);
        add_row(10'd248, 10'd248, 1'b1, 1'b0, '0);
        add_row(10'd247, 10'd16, 1'b1, 1'b0, '0);
        add_row(10'd249, 10'd8, 1'b0, 1'b0, '0);
        add_row(10'd300, 10'd24, 1'b0, 1'b0, '0);
        add_row(10'd1023, 10'd1023, 1'b0, 1'b0, '0);
        add_row(10'd0, 10'd1023, 1'b0, 1'b0, '0);
        add_row(10'd16, 10'd264, 1'b0, 1'b0, '0);
        add_row(10'd512, 10'd512, 1'b1, 1'b0, '0);
        add_row(10'd1016, 10'd8, 1'b0, 1'b0, '0);
        add_row(10'd8, 10'd1016, 1'b1, 1'b0, '0);
        add_row(10'd24, 10'd40, 1'b1, 1'b0, '0);
        add_row(10'd40, 10'd24, 1'b0, 1'b0, '0);
        add_row(10'd1000, 10'd3, 1'b0, 1'b0, '0);
        add_row(10'd513, 10'd257, 1'b0, 1'b0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].w, dir_rows[i].h, dir_rows[i].clip,
                         dir_rows[i].has_exp, dir_rows[i].exp);
        end

        // Mostly small requests so that the bitmap fills gradually over the run.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                w = 10'($urandom_range(0, 40));
                h = 10'($urandom_range(0, 40));
            end else if (pick < 94) begin
                w = 10'($urandom_range(0, 255));
                h = 10'($urandom_range(0, 255));
            end else begin
                w = 10'($urandom_range(0, 1023));
                h = 10'($urandom_range(0, 1023));
            end
            send_request(w, h, 1'($urandom), 1'b0, '0);
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending_allocs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Allocation requests issued: %0d, placed: %0d, refused: %0d.",
                 n_issued, n_placed, n_refused);
        $display("Final failure count %0d, mismatches %0d.", fail_total, err_count);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: atlas_rect_bitmap_allocator.f
rtl/arba_pkg.sv
rtl/arba_ram.sv
rtl/arba_fit.sv
rtl/atlas_rect_bitmap_allocator.sv
verif/atlas_rect_bitmap_allocator_tb.sv
